// ===== hw/rtl/tdq_pkg.sv =====
// ----------------------------------------------------------------------------
// tdq_pkg
// Shared types, codes and defaults for the timer deadline queue.
// ----------------------------------------------------------------------------
package tdq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    localparam int CMD_W      = 2;
    localparam int EVENT_ID_W = 8;
    localparam int TIME_W     = 64;
    localparam int STATUS_W   = 2;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    localparam logic KIND_FIRED  = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_UPD
    } t_state;

    typedef struct packed {
        logic ins;
        logic rem;
        logic pop;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/tdq_cell.sv =====
// ----------------------------------------------------------------------------
// tdq_cell
// One queue slot. Keeps, takes the new event, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module tdq_cell #(
    parameter int ID_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tdq_pkg::t_cell_ctl    i_ctl,
    input  logic [63:0]           i_new_dl,
    input  logic [ID_W-1:0]       i_new_id,
    input  logic                  i_new_nt,
    input  logic                  i_left_valid,
    input  logic [63:0]           i_left_dl,
    input  logic [ID_W-1:0]       i_left_id,
    input  logic                  i_left_nt,
    input  logic                  i_left_gt,
    input  logic                  i_right_valid,
    input  logic [63:0]           i_right_dl,
    input  logic [ID_W-1:0]       i_right_id,
    input  logic                  i_right_nt,
    input  logic                  i_sweep,
    output logic                  o_valid,
    output logic [63:0]           o_dl,
    output logic [ID_W-1:0]       o_id,
    output logic                  o_nt,
    output logic                  o_gt,
    output logic                  o_sweep
);
    import tdq_pkg::*;

    logic            r_valid;
    logic [63:0]     r_dl;
    logic [ID_W-1:0] r_id;
    logic            r_nt;
    logic            n_valid;
    logic [63:0]     n_dl;
    logic [ID_W-1:0] n_id;
    logic            n_nt;

    // gt: new event belongs at or before this slot
    assign o_gt    = !r_valid || (r_dl > i_new_dl);
    assign o_sweep = i_sweep || (r_valid && (r_id == i_new_id));

    always_comb begin
        n_valid = r_valid;
        n_dl    = r_dl;
        n_id    = r_id;
        n_nt    = r_nt;
        if (i_ctl.ins && o_gt) begin
            if (!i_left_gt) begin
                n_valid = 1'b1;
                n_dl    = i_new_dl;
                n_id    = i_new_id;
                n_nt    = i_new_nt;
            end else begin
                n_valid = i_left_valid;
                n_dl    = i_left_dl;
                n_id    = i_left_id;
                n_nt    = i_left_nt;
            end
        end else if (i_ctl.pop || (i_ctl.rem && o_sweep)) begin
            n_valid = i_right_valid;
            n_dl    = i_right_dl;
            n_id    = i_right_id;
            n_nt    = i_right_nt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl <= n_dl;
        r_id <= n_id;
        r_nt <= n_nt;
    end

    assign o_valid = r_valid;
    assign o_dl    = r_dl;
    assign o_id    = r_id;
    assign o_nt    = r_nt;

endmodule

// ===== hw/rtl/tdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdq_ctrl
// Command sequencer and result register for the timer deadline queue.
// ----------------------------------------------------------------------------
module tdq_ctrl #(
    parameter int ID_W = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [tdq_pkg::CMD_W-1:0]       i_command,
    input  logic [ID_W-1:0]                 i_event_id,
    input  logic [tdq_pkg::TIME_W-1:0]      i_deadline,
    input  logic                            i_notify,
    input  logic [tdq_pkg::TIME_W-1:0]      i_now_count,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_kind,
    output logic [tdq_pkg::EVENT_ID_W-1:0]  o_fired_id,
    output logic                            o_compare_enable,
    output logic [tdq_pkg::TIME_W-1:0]      o_compare_value,
    output logic [tdq_pkg::STATUS_W-1:0]    o_status,
    output logic                            o_last,
    input  logic                            i_head_valid,
    input  logic [tdq_pkg::TIME_W-1:0]      i_head_dl,
    input  logic [ID_W-1:0]                 i_head_id,
    input  logic                            i_head_nt,
    input  logic                            i_hit,
    input  logic                            i_full,
    output tdq_pkg::t_cell_ctl              o_ctl,
    output logic [tdq_pkg::TIME_W-1:0]      o_new_dl,
    output logic [ID_W-1:0]                 o_new_id,
    output logic                            o_new_nt
);
    import tdq_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [CMD_W-1:0]      r_cmd;
    logic [ID_W-1:0]       r_id;
    logic [TIME_W-1:0]     r_dl;
    logic                  r_nt;
    logic [TIME_W-1:0]     r_now;
    logic [STATUS_W-1:0]   r_status;
    logic [STATUS_W-1:0]   n_status;

    logic                  r_out_valid;
    logic                  r_kind;
    logic [EVENT_ID_W-1:0] r_fired_id;
    logic                  r_cmp_en;
    logic [TIME_W-1:0]     r_cmp_val;
    logic [STATUS_W-1:0]   r_out_status;
    logic                  r_last;

    logic                  out_free;
    logic                  accept;
    logic                  due;
    logic                  load_fired;
    logic                  load_update;

    assign out_free = !r_out_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign due      = i_head_valid && (i_head_dl <= r_now);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_command == CMD_TICK) ? S_TICK : S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_UPD;
            end
            S_TICK: begin
                if (!due) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (accept) begin
                    n_state = (i_command == CMD_TICK) ? S_TICK : S_EXEC;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        o_ctl       = '0;
        n_status    = r_status;
        load_fired  = 1'b0;
        load_update = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_EXEC: begin
                if (r_cmd == CMD_ADD) begin
                    if (i_hit) begin
                        n_status = ST_DUPLICATE;
                    end else if (i_full) begin
                        n_status = ST_FULL;
                    end else begin
                        o_ctl.ins = 1'b1;
                    end
                end else if (r_cmd == CMD_REMOVE) begin
                    if (i_hit) begin
                        o_ctl.rem = 1'b1;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
            end
            S_TICK: begin
                if (due && (!i_head_nt || out_free)) begin
                    o_ctl.pop  = 1'b1;
                    load_fired = i_head_nt;
                end
            end
            S_UPD: begin
                o_ready     = out_free;
                load_update = out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
        if (accept) begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_fired || load_update) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (accept) begin
            r_cmd <= i_command;
            r_id  <= i_event_id;
            r_dl  <= i_deadline;
            r_nt  <= i_notify;
            r_now <= i_now_count;
        end
        if (load_fired) begin
            r_kind       <= KIND_FIRED;
            r_fired_id   <= EVENT_ID_W'(i_head_id);
            r_cmp_en     <= 1'b0;
            r_cmp_val    <= '0;
            r_out_status <= ST_OK;
            r_last       <= 1'b0;
        end else if (load_update) begin
            r_kind       <= KIND_UPDATE;
            r_fired_id   <= '0;
            r_cmp_en     <= i_head_valid;
            r_cmp_val    <= i_head_valid ? i_head_dl : '0;
            r_out_status <= r_status;
            r_last       <= 1'b1;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_kind;
    assign o_fired_id       = r_fired_id;
    assign o_compare_enable = r_cmp_en;
    assign o_compare_value  = r_cmp_val;
    assign o_status         = r_out_status;
    assign o_last           = r_last;
    assign o_new_dl         = r_dl;
    assign o_new_id         = r_id;
    assign o_new_nt         = r_nt;

endmodule

// ===== hw/rtl/timer_deadline_queue_unit.sv =====
// ----------------------------------------------------------------------------
// timer_deadline_queue_unit
// Sorted timer event queue built as a chain of slots ordered by deadline.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) takes add, remove and tick commands.
// Output channel (o_valid/i_ready) returns results; each command ends with
// one comparator update marked by o_last, preceded on a tick by one fired
// result per expired event with notify set.
// Add and remove run back to back through the EXEC and UPD states: in EXEC
// every slot compares in parallel and shifts by one toward its neighbor; in
// UPD the update is sent and the next command is taken. A tick stays in
// TICK while the head has expired, popping the head slot once per cycle
// unless a fired result has to wait for the output register, then sends the
// update in UPD. Results are held in one output register; while the
// receiver stalls, pops with a fired result and the update wait and no new
// command is taken. Reset empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
module timer_deadline_queue_unit #(
    parameter int QUEUE_DEPTH = tdq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = tdq_pkg::ID_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [tdq_pkg::CMD_W-1:0]       i_command,
    input  logic [tdq_pkg::EVENT_ID_W-1:0]  i_event_id,
    input  logic [tdq_pkg::TIME_W-1:0]      i_deadline,
    input  logic                            i_notify,
    input  logic [tdq_pkg::TIME_W-1:0]      i_now_count,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_kind,
    output logic [tdq_pkg::EVENT_ID_W-1:0]  o_fired_id,
    output logic                            o_compare_enable,
    output logic [tdq_pkg::TIME_W-1:0]      o_compare_value,
    output logic [tdq_pkg::STATUS_W-1:0]    o_status,
    output logic                            o_last
);
    import tdq_pkg::*;

    localparam int ID_W = (ID_BITS < EVENT_ID_W) ? ID_BITS : EVENT_ID_W;

    t_cell_ctl         ctl;
    logic [TIME_W-1:0] new_dl;
    logic [ID_W-1:0]   new_id;
    logic              new_nt;

    logic              c_valid [QUEUE_DEPTH];
    logic [TIME_W-1:0] c_dl    [QUEUE_DEPTH];
    logic [ID_W-1:0]   c_id    [QUEUE_DEPTH];
    logic              c_nt    [QUEUE_DEPTH];
    logic              c_gt    [QUEUE_DEPTH];
    logic              c_sweep [QUEUE_DEPTH];

    tdq_ctrl #(
        .ID_W (ID_W)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_event_id       (i_event_id[ID_W-1:0]),
        .i_deadline       (i_deadline),
        .i_notify         (i_notify),
        .i_now_count      (i_now_count),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_fired_id       (o_fired_id),
        .o_compare_enable (o_compare_enable),
        .o_compare_value  (o_compare_value),
        .o_status         (o_status),
        .o_last           (o_last),
        .i_head_valid     (c_valid[0]),
        .i_head_dl        (c_dl[0]),
        .i_head_id        (c_id[0]),
        .i_head_nt        (c_nt[0]),
        .i_hit            (c_sweep[QUEUE_DEPTH-1]),
        .i_full           (c_valid[QUEUE_DEPTH-1]),
        .o_ctl            (ctl),
        .o_new_dl         (new_dl),
        .o_new_id         (new_id),
        .o_new_nt         (new_nt)
    );

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic              left_valid;
        logic [TIME_W-1:0] left_dl;
        logic [ID_W-1:0]   left_id;
        logic              left_nt;
        logic              left_gt;
        logic              right_valid;
        logic [TIME_W-1:0] right_dl;
        logic [ID_W-1:0]   right_id;
        logic              right_nt;
        logic              sweep_in;

        if (g == 0) begin : g_head
            assign left_valid = 1'b0;
            assign left_dl    = '0;
            assign left_id    = '0;
            assign left_nt    = 1'b0;
            assign left_gt    = 1'b0;
            assign sweep_in   = 1'b0;
        end else begin : g_body
            assign left_valid = c_valid[g-1];
            assign left_dl    = c_dl[g-1];
            assign left_id    = c_id[g-1];
            assign left_nt    = c_nt[g-1];
            assign left_gt    = c_gt[g-1];
            assign sweep_in   = c_sweep[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_dl    = '0;
            assign right_id    = '0;
            assign right_nt    = 1'b0;
        end else begin : g_inner
            assign right_valid = c_valid[g+1];
            assign right_dl    = c_dl[g+1];
            assign right_id    = c_id[g+1];
            assign right_nt    = c_nt[g+1];
        end

        tdq_cell #(
            .ID_W (ID_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_new_dl      (new_dl),
            .i_new_id      (new_id),
            .i_new_nt      (new_nt),
            .i_left_valid  (left_valid),
            .i_left_dl     (left_dl),
            .i_left_id     (left_id),
            .i_left_nt     (left_nt),
            .i_left_gt     (left_gt),
            .i_right_valid (right_valid),
            .i_right_dl    (right_dl),
            .i_right_id    (right_id),
            .i_right_nt    (right_nt),
            .i_sweep       (sweep_in),
            .o_valid       (c_valid[g]),
            .o_dl          (c_dl[g]),
            .o_id          (c_id[g]),
            .o_nt          (c_nt[g]),
            .o_gt          (c_gt[g]),
            .o_sweep       (c_sweep[g])
        );
    end

endmodule
